// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int MAX_BLOCK_SIZE = 4096;

  localparam int OFF_W      = 20;
  localparam int LIMIT_W    = 9;
  localparam int SIZE_W     = 13;
  localparam int CNT_W      = 9;
  localparam int BIDX_W     = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_BITS   = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd512;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREED = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic hit_cap;
    logic mul;
    logic fchk;
    logic frd_cap;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic exhausted;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bba_ifs.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
interface bba_req_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [bba_pkg::OFF_W-1:0] free_offset;

  modport source (output valid, output opcode, output free_offset, input ready);
  modport sink   (input valid, input opcode, input free_offset, output ready);
endinterface

interface bba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [bba_pkg::BIDX_W-1:0] block_index;
  logic [bba_pkg::OFF_W-1:0]  block_offset;
  logic [bba_pkg::CNT_W-1:0]  used_count;

  modport source (output valid, output status, output block_index, output block_offset,
                  output used_count, input ready);
  modport sink   (input valid, input status, input block_index, input block_offset,
                  input used_count, output ready);
endinterface

interface bba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::CFG_IDX_W-1:0]  index;
  logic [bba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bba_div.sv =====
// Restoring divider, one quotient bit per cycle, for free offset to block index.
module bba_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bba_pkg::OFF_W-1:0]  dividend,
  input  logic [bba_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [bba_pkg::OFF_W-1:0]  quotient
);
  import bba_pkg::*;

  localparam int CW = $clog2(OFF_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [OFF_W-1:0]  q;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem, q[OFF_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(OFF_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[OFF_W-2:0], ge};
      rem <= ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
    end
  end

  assign quotient = q;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hw/rtl/bba_dp.sv =====
// Datapath: used-bit map memory, scan, divider, offset multiply, count and result register.
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::ctrl_cmd_t            cmd,
  output bba_pkg::dp_stat_t             stat,
  input  logic                          cfg_valid,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          cfg_ready,
  input  logic                          req_opcode,
  input  logic [bba_pkg::OFF_W-1:0]      req_free_offset,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [1:0]                    rsp_status,
  output logic [bba_pkg::BIDX_W-1:0]     rsp_block_index,
  output logic [bba_pkg::OFF_W-1:0]      rsp_block_offset,
  output logic [bba_pkg::CNT_W-1:0]      rsp_used_count
);
  import bba_pkg::*;

  localparam int ROWS   = MAX_BLOCKS / ROW_BITS;
  localparam int RA_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W   = $clog2(ROWS + 1);
  localparam int LRW    = (RC_W > 6) ? RC_W : 6;
  localparam int IDX_W  = RA_W + 3;
  localparam int PW     = IDX_W + SIZE_W + OFF_W;
  localparam int CMPW   = OFF_W + LRW + 3;

  logic [ROW_BITS-1:0] mem [ROWS];

  logic [LIMIT_W-1:0] lim_cfg;
  logic [SIZE_W-1:0]  size_cfg;
  logic [SIZE_W-1:0]  act_size;
  logic [LRW-1:0]     act_rows;

  logic               op;
  logic [LRW-1:0]     lim_rows;
  logic [SIZE_W-1:0]  size;
  logic [LRW-1:0]     ptr;
  logic               rd_vld;
  logic [RA_W-1:0]    rd_row;
  logic [ROW_BITS-1:0] rd_data;
  logic               found;
  logic               inr;
  logic               dec;
  logic [RA_W-1:0]    wr_row;
  logic [ROW_BITS-1:0] wr_val;
  logic [IDX_W-1:0]   idx;
  logic [OFF_W-1:0]   boff;
  logic [CNT_W-1:0]   count;
  logic [RC_W-1:0]    clr_ptr;

  logic               div_done;
  logic [OFF_W-1:0]   quot;
  logic               scan_more;
  logic               clr_done;
  logic [2:0]         zbit;
  logic               rd_en;
  logic [RA_W-1:0]    rd_addr;
  logic               we;
  logic [RA_W-1:0]    wa;
  logic [ROW_BITS-1:0] wd;
  logic [PW-1:0]      prod;
  logic [CMPW-1:0]    q_ext;
  logic [CMPW-1:0]    lim_ext;
  logic [IDX_W+BIDX_W-1:0] idx_ext;
  logic               upd;
  logic [CNT_W-1:0]   count_next;
  status_t            st_next;
  logic [BIDX_W-1:0]  bidx_next;
  logic [OFF_W-1:0]   boff_next;

  // active limit in rows of eight, capped at the map depth
  assign act_rows = (LRW'(lim_cfg[LIMIT_W-1:3]) > LRW'(ROWS)) ? LRW'(ROWS)
                                                              : LRW'(lim_cfg[LIMIT_W-1:3]);
  always_comb begin
    act_size = size_cfg;
    if (size_cfg == '0) begin
      act_size = SIZE_W'(1);
    end else if (size_cfg > SIZE_W'(MAX_BLOCK_SIZE)) begin
      act_size = SIZE_W'(MAX_BLOCK_SIZE);
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_cfg  <= LIMIT_RESET;
      size_cfg <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT: lim_cfg  <= cfg_data[LIMIT_W-1:0];
        CFG_SIZE:  size_cfg <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  bba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load && req_opcode == OP_FREE),
    .dividend (req_free_offset),
    .divisor  (act_size),
    .done     (div_done),
    .quotient (quot)
  );

  assign scan_more = ptr < lim_rows;
  assign clr_done  = clr_ptr == RC_W'(ROWS);

  always_comb begin
    zbit = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!rd_data[i]) zbit = 3'(i);
    end
  end

  assign stat.clr_done  = clr_done;
  assign stat.hit       = rd_vld && (rd_data != '1);
  assign stat.exhausted = !scan_more && !rd_vld;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // map memory ports
  assign rd_en   = (cmd.scan && scan_more) || cmd.fchk;
  assign rd_addr = cmd.fchk ? quot[RA_W+2:3] : ptr[RA_W-1:0];
  assign upd     = (op == OP_ALLOC) ? found : inr;
  assign we      = (cmd.clr && !clr_done) || (cmd.emit && upd);
  assign wa      = cmd.clr ? clr_ptr[RA_W-1:0] : wr_row;
  assign wd      = cmd.clr ? '0 : wr_val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign prod    = PW'(idx) * PW'(size);
  assign q_ext   = CMPW'(quot);
  assign lim_ext = CMPW'({lim_rows, 3'b000});
  assign idx_ext = {{BIDX_W{1'b0}}, idx};

  always_comb begin
    count_next = count;
    st_next    = ST_FULL;
    bidx_next  = '0;
    boff_next  = '0;
    if (op == OP_ALLOC) begin
      if (found) begin
        st_next    = ST_ALLOC;
        count_next = count + CNT_W'(1);
        bidx_next  = idx_ext[BIDX_W-1:0];
        boff_next  = boff;
      end
    end else if (inr) begin
      st_next    = ST_FREED;
      count_next = count - CNT_W'(dec);
      bidx_next  = idx_ext[BIDX_W-1:0];
    end else begin
      st_next = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      inr       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr && !clr_done) begin
        clr_ptr <= clr_ptr + RC_W'(1);
      end
      if (cmd.load) begin
        rd_vld <= 1'b0;
        found  <= 1'b0;
        inr    <= 1'b0;
      end
      if (cmd.scan) begin
        rd_vld <= scan_more;
      end
      if (cmd.hit_cap) begin
        found <= 1'b1;
      end
      if (cmd.fchk) begin
        inr <= q_ext < lim_ext;
      end
      if (cmd.emit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req_opcode;
      lim_rows <= act_rows;
      size     <= act_size;
      ptr      <= '0;
    end
    if (cmd.scan && scan_more) begin
      ptr    <= ptr + LRW'(1);
      rd_row <= ptr[RA_W-1:0];
    end
    if (cmd.hit_cap) begin
      wr_row <= rd_row;
      wr_val <= rd_data | (ROW_BITS'(1) << zbit);
      idx    <= {rd_row, zbit};
    end
    if (cmd.mul) begin
      boff <= prod[OFF_W-1:0];
    end
    if (cmd.fchk) begin
      idx <= quot[IDX_W-1:0];
    end
    if (cmd.frd_cap) begin
      wr_row <= idx[IDX_W-1:3];
      wr_val <= rd_data & ~(ROW_BITS'(1) << idx[2:0]);
      dec    <= rd_data[idx[2:0]];
    end
    if (cmd.emit) begin
      rsp_status       <= st_next;
      rsp_block_index  <= bidx_next;
      rsp_block_offset <= boff_next;
      rsp_used_count   <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.emit |=> $stable(count))
    else $error("block count changed without a result");
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && op == OP_ALLOC && found |=> count == $past(count) + CNT_W'(1))
    else $error("allocation did not bump the block count");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> rsp_valid)
    else $error("result lost");
`endif

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine: clearing pass, allocate scan and free sequence.
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_opcode,
  output logic               req_ready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::ctrl_cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_FCHK  = 8'b0010_0000,
    S_FRD   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_opcode == OP_FREE) ? S_DIV : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.hit_cap = 1'b1;
          state_next  = S_MUL;
        end else if (stat.exhausted) begin
          state_next = S_EMIT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EMIT;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_FCHK;
      end
      S_FCHK: begin
        cmd.fchk   = 1'b1;
        state_next = S_FRD;
      end
      S_FRD: begin
        cmd.frd_cap = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_SCAN || state == S_DIV)
    else $error("accepted transaction not dispatched");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && !stat.div_done |=> state == S_DIV)
    else $error("left divide before quotient ready");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == S_IDLE)
    else $error("no return to idle after result");
`endif

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator.
// Bitmap block allocator: one used bit per block, held in a memory of rows of eight bits.
// After reset a clearing pass writes MAX_BLOCKS/8 rows, one per cycle, before the first
// request is taken; configuration writes are accepted at any time and take effect on the
// next request. An allocate reads one row per cycle from the map until it finds a row with
// a free bit, scanning up to limit/8 rows (at most MAX_BLOCKS/8).
// A free divides the offset by the block size in a one-bit-per-cycle divider. One request
// is in flight at a time; the result register lets the next request be accepted while the
// previous result waits to be taken.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bba_cfg_if.sink   cfg,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .cfg_ready        (cfg.ready),
    .req_opcode       (req.opcode),
    .req_free_offset  (req.free_offset),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_block_index  (rsp.block_index),
    .rsp_block_offset (rsp.block_offset),
    .rsp_used_count   (rsp.used_count)
  );

endmodule

// ===== test/tb_bitmap_block_allocator.sv =====
// Testbench for the bitmap block allocator: directed table, then random traffic vs. a predictor.
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    status_t             status;
    logic [BIDX_W-1:0]   index;
    logic [OFF_W-1:0]    offset;
    logic [CNT_W-1:0]    count;
  } outcome_t;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_DATA_W-1:0] lim_data;
    logic [CFG_DATA_W-1:0] size_data;
    logic                  op;
    logic [OFF_W-1:0]      off;
    bit                    typed;
    outcome_t              want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  bba_cfg_if cfg_if ();
  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  bitmap_block_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #2 clk = ~clk;

  // allocator image
  logic [MAX_BLOCKS_DEF-1:0] busy_map;
  logic [CNT_W-1:0]          busy_count;
  logic [LIMIT_W-1:0]        limit_reg;
  logic [SIZE_W-1:0]         size_reg;

  outcome_t    pending_outcomes[$];
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  logic        no_gaps = 1'b0;
  int unsigned hold_req_cnt = 0;

  function automatic int unsigned eff_limit();
    int unsigned lim;
    lim = limit_reg & 9'h1f8;
    if (lim > MAX_BLOCKS_DEF) lim = MAX_BLOCKS_DEF;
    return lim;
  endfunction

  function automatic int unsigned eff_size();
    int unsigned sz;
    sz = size_reg;
    if (sz == 0) sz = 1;
    if (sz > MAX_BLOCK_SIZE) sz = MAX_BLOCK_SIZE;
    return sz;
  endfunction

  function automatic outcome_t next_outcome(input logic op, input logic [OFF_W-1:0] off);
    outcome_t    o;
    int unsigned lim;
    int unsigned sz;
    int unsigned blk;
    bit          found;
    lim = eff_limit();
    sz = eff_size();
    o.status = ST_FULL;
    o.index = '0;
    o.offset = '0;
    found = 1'b0;
    blk = 0;
    if (op == OP_ALLOC) begin
      for (int k = 0; k < lim; k++) begin
        if (!busy_map[k]) begin
          blk = k;
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        busy_map[blk] = 1'b1;
        busy_count = busy_count + 1'b1;
        o.status = ST_ALLOC;
        o.index = BIDX_W'(blk);
        o.offset = OFF_W'(blk * sz);
      end
    end else begin
      blk = off / sz;
      if (blk >= lim) begin
        o.status = ST_RANGE;
      end else begin
        if (busy_map[blk]) begin
          busy_map[blk] = 1'b0;
          busy_count = busy_count - 1'b1;
        end
        o.status = ST_FREED;
        o.index = BIDX_W'(blk);
      end
    end
    o.count = busy_count;
    return o;
  endfunction

  function automatic plan_row_t cfg_step(input logic [CFG_DATA_W-1:0] lim,
                                         input logic [CFG_DATA_W-1:0] sz);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.lim_data = lim;
    r.size_data = sz;
    return r;
  endfunction

  function automatic plan_row_t op_step(input logic op, input logic [OFF_W-1:0] off);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.off = off;
    return r;
  endfunction

  function automatic plan_row_t known_step(input logic op, input logic [OFF_W-1:0] off,
                                           input status_t st, input int unsigned idx,
                                           input int unsigned boff, input int unsigned cnt);
    plan_row_t r;
    r = op_step(op, off);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.index = BIDX_W'(idx);
    r.want.offset = OFF_W'(boff);
    r.want.count = CNT_W'(cnt);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 50)
      $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
  endtask

  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] lim_data,
                              input logic [CFG_DATA_W-1:0] size_data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_LIMIT;
    cfg_if.data <= lim_data;
    do @(posedge clk); while (!cfg_if.ready);
    limit_reg = lim_data[LIMIT_W-1:0];
    cfg_if.index <= CFG_SIZE;
    cfg_if.data <= size_data;
    do @(posedge clk); while (!cfg_if.ready);
    size_reg = size_data[SIZE_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_req(input logic op, input logic [OFF_W-1:0] off, input bit typed,
                          input outcome_t want);
    outcome_t e;
    if (!no_gaps && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.free_offset <= off;
    do @(posedge clk); while (!req_if.ready);
    e = next_outcome(op, off);
    if (typed) e = want;
    pending_outcomes.push_back(e);
  endtask

  // response side: random backpressure plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_gaps || ($urandom_range(99) >= 8);
      end
    end
  end

  // response checker
  initial begin
    outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("response with no transaction pending", rsp_if.status, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.block_index !== want.index)
            report_mismatch("block_index", rsp_if.block_index, want.index);
          if (rsp_if.block_offset !== want.offset)
            report_mismatch("block_offset", rsp_if.block_offset, want.offset);
          if (rsp_if.used_count !== want.count)
            report_mismatch("used_count", rsp_if.used_count, want.count);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_bitmap_block_allocator: done, errors");
    $finish;
  end

  initial begin
    outcome_t              blank;
    int unsigned           random_sent;
    int unsigned           phase;
    int unsigned           burst;
    int unsigned           pick;
    int unsigned           lim;
    int unsigned           sz;
    int unsigned           blk;
    int unsigned           start;
    int unsigned           j;
    int unsigned           span;
    logic                  op;
    logic [OFF_W-1:0]      off;
    logic [LIMIT_W-1:0]    lim9;
    logic [CFG_DATA_W-1:0] lim_data;
    logic [CFG_DATA_W-1:0] size_data;

    blank = '0;
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_LIMIT;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_ALLOC;
    req_if.free_offset = '0;
    busy_map = '0;
    busy_count = '0;
    limit_reg = LIMIT_RESET;
    size_reg = SIZE_RESET;

    plan.push_back(known_step(OP_ALLOC, 0, ST_ALLOC, 0, 0, 1));
    plan.push_back(known_step(OP_ALLOC, 0, ST_ALLOC, 1, 512, 2));
    plan.push_back(known_step(OP_FREE, 512, ST_FREED, 1, 0, 1));
    plan.push_back(known_step(OP_FREE, 512, ST_FREED, 1, 0, 1));
    plan.push_back(known_step(OP_FREE, 20'hfffff, ST_RANGE, 0, 0, 1));
    plan.push_back(known_step(OP_FREE, 0, ST_FREED, 0, 0, 0));
    plan.push_back(known_step(OP_FREE, 130560, ST_FREED, 255, 0, 0));
    plan.push_back(known_step(OP_FREE, 131072, ST_RANGE, 0, 0, 0));
    plan.push_back(cfg_step(7, 512));
    plan.push_back(known_step(OP_ALLOC, 0, ST_FULL, 0, 0, 0));
    plan.push_back(known_step(OP_FREE, 0, ST_RANGE, 0, 0, 0));
    plan.push_back(cfg_step(13'h1e08, 512));
    repeat (8) plan.push_back(op_step(OP_ALLOC, 20'h5a5a5));
    plan.push_back(known_step(OP_ALLOC, 0, ST_FULL, 0, 0, 8));
    plan.push_back(cfg_step(8, 0));
    plan.push_back(known_step(OP_FREE, 3, ST_FREED, 3, 0, 7));
    plan.push_back(known_step(OP_FREE, 8, ST_RANGE, 0, 0, 7));
    plan.push_back(known_step(OP_ALLOC, 0, ST_ALLOC, 3, 3, 8));
    plan.push_back(cfg_step(0, 1));
    plan.push_back(known_step(OP_ALLOC, 0, ST_FULL, 0, 0, 8));
    plan.push_back(known_step(OP_FREE, 0, ST_RANGE, 0, 0, 8));
    plan.push_back(cfg_step(511, 8191));
    plan.push_back(known_step(OP_ALLOC, 0, ST_ALLOC, 8, 32768, 9));
    plan.push_back(known_step(OP_FREE, 20'hfffff, ST_FREED, 255, 0, 9));
    plan.push_back(cfg_step(256, 4095));
    plan.push_back(known_step(OP_FREE, 20'hfffff, ST_RANGE, 0, 0, 9));
    plan.push_back(op_step(OP_FREE, 20475));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        drain_requests();
        program_regs(plan[n].lim_data, plan[n].size_data);
      end else begin
        send_req(plan[n].op, plan[n].off, plan[n].typed, plan[n].want);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_requests();
      no_gaps <= (phase == 3);
      if (phase == 4) hold_req_cnt <= hold_req_cnt + 1;
      if (phase == 2) begin
        // fill the whole map and run past full
        lim_data = {4'($urandom_range(0, 15)), 9'd256};
        size_data = 13'd4096;
        burst = 300;
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: lim9 = 9'($urandom_range(0, 7));
          1: lim9 = 9'($urandom_range(256, 511));
          default: lim9 = 9'($urandom_range(8, 72));
        endcase
        lim_data = {4'($urandom_range(0, 15)), lim9};
        pick = $urandom_range(0, 9);
        case (pick)
          0: size_data = '0;
          1: size_data = 13'($urandom_range(4097, 8191));
          2: size_data = 13'd4096;
          3: size_data = 13'd1;
          4: size_data = 13'($urandom);
          default: size_data = 13'($urandom_range(2, 700));
        endcase
        burst = $urandom_range(30, 90);
      end
      program_regs(lim_data, size_data);

      for (int n = 0; n < burst; n++) begin
        lim = eff_limit();
        sz = eff_size();
        if (phase == 2)
          op = OP_ALLOC;
        else if (busy_count * 2 < lim)
          op = ($urandom_range(99) < 65) ? OP_ALLOC : OP_FREE;
        else
          op = ($urandom_range(99) < 35) ? OP_ALLOC : OP_FREE;
        off = 20'($urandom);
        if (op == OP_FREE && $urandom_range(99) < 80) begin
          blk = $urandom_range(0, lim + 3);
          if ($urandom_range(99) < 70) begin
            start = $urandom_range(0, MAX_BLOCKS_DEF - 1);
            for (int k = 0; k < MAX_BLOCKS_DEF; k++) begin
              j = (start + k) % MAX_BLOCKS_DEF;
              if (busy_map[j] && j < lim) begin
                blk = j;
                break;
              end
            end
          end
          span = blk * sz + $urandom_range(0, sz - 1);
          off = (span > 20'hfffff) ? 20'hfffff : 20'(span);
        end
        send_req(op, off, 1'b0, blank);
        random_sent++;
      end
      phase++;
    end

    drain_requests();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bitmap_block_allocator: done, clean");
    end else begin
      $display("tb_bitmap_block_allocator: done, errors");
    end
    $finish;
  end

endmodule
